// ----- rtl/ecefenu_pkg.sv -----
`timescale 1ns / 1ps

package ecefenu_pkg;

   // One fix in ECEF centimetres
   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
   } pos_type;

   // One local offset in centimetres
   typedef struct packed {
      logic signed [31:0] east;
      logic signed [31:0] north;
      logic signed [31:0] up;
   } enu_type;

   // Wrapped difference of a fix from the reference
   typedef struct packed {
      logic signed [31:0] dx;
      logic signed [31:0] dy;
      logic signed [31:0] dz;
   } diff_type;

   // Word k: east x,y,z, north x,y,z, up x,y,z
   typedef logic [8:0][31:0] basis_type;

   localparam int QUEUE_DEPTH = 4;
   localparam int OUT_DEPTH   = 4;

   localparam logic [63:0] NANO_SCALE = 64'd1000000000;
   // inverse flattening times 1e9, minus 1e9
   localparam logic [63:0] FLAT_DEN   = 64'd297257223563;

   // Reciprocal form of the z stretch: for m up to 2^31,
   // (m * ZREC_MUL + ZREC_BIAS) >> ZREC_SHIFT is round(m * NANO_SCALE / FLAT_DEN)
   localparam int ZREC_SHIFT = 70;
   localparam logic [127:0] ZREC_MUL =
      ((128'd1 << ZREC_SHIFT) * 128'(NANO_SCALE) + 128'(FLAT_DEN) - 128'd1)
      / 128'(FLAT_DEN);
   localparam logic [95:0] ZREC_BIAS =
      96'(((128'd1 << ZREC_SHIFT) * 128'(FLAT_DEN >> 1) + 128'(FLAT_DEN) - 128'd1)
      / 128'(FLAT_DEN));
   localparam logic [30:0] ZREC_LO = ZREC_MUL[30:0];
   localparam logic [30:0] ZREC_HI = ZREC_MUL[61:31];

   // Arithmetic right shift by k, rounded half away from zero
   function automatic logic signed [63:0] shr_round(input logic signed [63:0] v,
                                                    input int unsigned k);
      logic [63:0] mag;
      logic [63:0] m;
      mag = v[63] ? 64'(-v) : 64'(v);
      m   = (mag + (64'd1 << (k - 1))) >> k;
      return v[63] ? -$signed(m) : $signed(m);
   endfunction

endpackage

// ----- rtl/ecefenu_divu.sv -----
`timescale 1ns / 1ps

// Unsigned 64 / 64 restoring divider, one quotient bit per cycle
module ecefenu_divu (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] num,
   input  logic [63:0] den,
   output logic        done,
   output logic [63:0] quo
);

   logic        busy_ff;
   logic        done_ff;
   logic [5:0]  cnt_ff;
   logic [64:0] rem_ff;
   logic [63:0] quo_ff;
   logic [63:0] den_ff;
   logic [64:0] rem_shift;

   assign rem_shift = {rem_ff[63:0], quo_ff[63]};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= busy_ff && (cnt_ff == 6'd63);
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 6'd1;
            if (cnt_ff == 6'd63) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= num;
         den_ff <= den;
      end else if (busy_ff) begin
         if (rem_shift >= {1'b0, den_ff}) begin
            rem_ff <= rem_shift - {1'b0, den_ff};
            quo_ff <= {quo_ff[62:0], 1'b1};
         end else begin
            rem_ff <= rem_shift;
            quo_ff <= {quo_ff[62:0], 1'b0};
         end
      end
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

// ----- rtl/ecefenu_isqrt.sv -----
`timescale 1ns / 1ps

// Floor square root of a 64-bit value, one root bit per cycle
module ecefenu_isqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] radicand,
   output logic        done,
   output logic [31:0] root
);

   logic        busy_ff;
   logic        done_ff;
   logic [4:0]  cnt_ff;
   logic [63:0] rad_ff;
   logic [34:0] rem_ff;
   logic [31:0] root_ff;
   logic [34:0] rem_next;
   logic [34:0] trial;

   assign rem_next = {rem_ff[32:0], rad_ff[63:62]};
   assign trial    = {1'b0, root_ff, 2'b01};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= busy_ff && (cnt_ff == 5'd31);
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rad_ff  <= radicand;
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (busy_ff) begin
         rad_ff <= {rad_ff[61:0], 2'b00};
         if (rem_next >= trial) begin
            rem_ff  <= rem_next - trial;
            root_ff <= {root_ff[30:0], 1'b1};
         end else begin
            rem_ff  <= rem_next;
            root_ff <= {root_ff[30:0], 1'b0};
         end
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

// ----- rtl/ecefenu_basis.sv -----
`timescale 1ns / 1ps

// Builds the east/north/up basis from the reference fix with one shared
// multiplier, a serial divider and a serial square root.
module ecefenu_basis #(
   parameter int BASIS_FRAC_BITS = 30
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  ecefenu_pkg::pos_type   ref_pos,
   output logic                   ready,
   output ecefenu_pkg::basis_type basis
);

   localparam logic signed [63:0] UNIT = 64'sd1 <<< BASIS_FRAC_BITS;

   typedef enum logic [15:0] {
      ST_IDLE   = 16'h0001,
      ST_ZMUL   = 16'h0002,
      ST_ZDIV   = 16'h0004,
      ST_ZWAIT  = 16'h0008,
      ST_NSQ    = 16'h0010,
      ST_NACC   = 16'h0020,
      ST_NROOT  = 16'h0040,
      ST_NRWAIT = 16'h0080,
      ST_NDIV   = 16'h0100,
      ST_NDWAIT = 16'h0200,
      ST_TMUL   = 16'h0400,
      ST_TACC   = 16'h0800,
      ST_EMUL1  = 16'h1000,
      ST_EMUL2  = 16'h2000,
      ST_EACC   = 16'h4000,
      ST_DONE   = 16'h8000
   } state_type;

   state_type          state_ff, state_in;
   logic [1:0]         idx_ff, idx_in;
   logic               pass_ff;
   logic               ready_ff;
   ecefenu_pkg::pos_type ref_ff;
   logic signed [33:0] c_ff [3];
   logic signed [31:0] u_ff [3];
   logic signed [31:0] nv_ff [3];
   logic signed [31:0] e_ff [3];
   logic signed [67:0] prod_ff;
   logic signed [63:0] p1_ff;
   logic [63:0]        sum_ff;
   logic [31:0]        n_ff;

   logic [1:0]         idx_p1, idx_m1;
   logic signed [33:0] c_sel, c_mag;
   logic signed [33:0] mul_a, mul_b;
   logic signed [33:0] z_abs;
   logic [95:0]        z_sum;
   logic [31:0]        z_quo;
   logic signed [63:0] t_shr, e_shr;
   logic signed [31:0] e_clamp;
   logic [31:0]        q32, norm_word;
   logic               norm_write, adv;

   logic               div_start, div_done;
   logic [63:0]        div_num, div_den, div_quo;
   logic               sq_start, sq_done;
   logic [31:0]        sq_root;

   assign idx_p1 = (idx_ff == 2'd2) ? 2'd0 : idx_ff + 2'd1;
   assign idx_m1 = (idx_ff == 2'd0) ? 2'd2 : idx_ff - 2'd1;
   assign c_sel  = c_ff[idx_ff];
   assign c_mag  = c_sel[33] ? -c_sel : c_sel;
   assign z_abs  = ref_ff.pos_z[31] ? -34'(ref_ff.pos_z) : 34'(ref_ff.pos_z);

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_ZMUL: begin
            mul_a = z_abs;
            mul_b = 34'(ecefenu_pkg::ZREC_LO);
         end
         ST_ZDIV: begin
            mul_a = z_abs;
            mul_b = 34'(ecefenu_pkg::ZREC_HI);
         end
         ST_NSQ: begin
            mul_a = c_mag;
            mul_b = c_mag;
         end
         ST_TMUL: begin
            mul_a = 34'(u_ff[idx_ff]);
            mul_b = 34'(u_ff[2]);
         end
         ST_EMUL1: begin
            mul_a = 34'(nv_ff[idx_p1]);
            mul_b = 34'(u_ff[idx_m1]);
         end
         ST_EMUL2: begin
            mul_a = 34'(nv_ff[idx_m1]);
            mul_b = 34'(u_ff[idx_p1]);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // z stretch by reciprocal: high partial product in prod_ff, low one in p1_ff
   assign z_sum = (96'(prod_ff[63:0]) << 31) + 96'(p1_ff[62:0])
                + ecefenu_pkg::ZREC_BIAS;
   assign z_quo = 32'(z_sum[95:ecefenu_pkg::ZREC_SHIFT]);

   assign t_shr = ecefenu_pkg::shr_round(prod_ff[63:0], BASIS_FRAC_BITS);
   assign e_shr = ecefenu_pkg::shr_round(p1_ff - prod_ff[63:0], BASIS_FRAC_BITS);

   always_comb begin
      if (e_shr > UNIT) begin
         e_clamp = 32'(UNIT);
      end else if (e_shr < -UNIT) begin
         e_clamp = 32'(-UNIT);
      end else begin
         e_clamp = e_shr[31:0];
      end
   end

   assign q32       = div_quo[31:0];
   assign norm_word = (n_ff == '0) ? '0 : (c_sel[33] ? -q32 : q32);
   assign norm_write = (state_ff == ST_NDIV && n_ff == '0)
                    || (state_ff == ST_NDWAIT && div_done);
   assign adv = norm_write;

   assign div_start = (state_ff == ST_NDIV && n_ff != '0);
   assign div_num   = (64'(c_mag) << BASIS_FRAC_BITS) + 64'(n_ff >> 1);
   assign div_den   = 64'(n_ff);
   assign sq_start  = (state_ff == ST_NROOT);

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      case (state_ff)
         ST_IDLE:   if (start) state_in = ST_ZMUL;
         ST_ZMUL:   state_in = ST_ZDIV;
         ST_ZDIV:   state_in = ST_ZWAIT;
         ST_ZWAIT: begin
            state_in = ST_NSQ;
            idx_in   = 2'd0;
         end
         ST_NSQ:    state_in = ST_NACC;
         ST_NACC: begin
            if (idx_ff == 2'd2) begin
               state_in = ST_NROOT;
               idx_in   = 2'd0;
            end else begin
               state_in = ST_NSQ;
               idx_in   = idx_p1;
            end
         end
         ST_NROOT:  state_in = ST_NRWAIT;
         ST_NRWAIT: if (sq_done) state_in = ST_NDIV;
         ST_NDIV, ST_NDWAIT: begin
            if (state_ff == ST_NDIV && n_ff != '0) begin
               state_in = ST_NDWAIT;
            end else if (adv) begin
               if (idx_ff == 2'd2) begin
                  idx_in   = 2'd0;
                  state_in = pass_ff ? ST_EMUL1 : ST_TMUL;
               end else begin
                  idx_in   = idx_p1;
                  state_in = ST_NDIV;
               end
            end
         end
         ST_TMUL:   state_in = ST_TACC;
         ST_TACC: begin
            if (idx_ff == 2'd2) begin
               state_in = ST_NSQ;
               idx_in   = 2'd0;
            end else begin
               state_in = ST_TMUL;
               idx_in   = idx_p1;
            end
         end
         ST_EMUL1:  state_in = ST_EMUL2;
         ST_EMUL2:  state_in = ST_EACC;
         ST_EACC: begin
            if (idx_ff == 2'd2) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_EMUL1;
               idx_in   = idx_p1;
            end
         end
         ST_DONE:   state_in = ST_DONE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
         pass_ff  <= 1'b0;
         ready_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         if (state_ff == ST_TACC && idx_ff == 2'd2) begin
            pass_ff <= 1'b1;
         end
         if (state_ff == ST_DONE) begin
            ready_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      case (state_ff)
         ST_IDLE: if (start) ref_ff <= ref_pos;
         ST_ZDIV:   p1_ff <= prod_ff[63:0];
         ST_ZWAIT: begin
            c_ff[0] <= 34'(ref_ff.pos_x);
            c_ff[1] <= 34'(ref_ff.pos_y);
            c_ff[2] <= 34'(ref_ff.pos_z)
                     + (ref_ff.pos_z[31] ? -34'(z_quo) : 34'(z_quo));
            sum_ff  <= '0;
         end
         ST_NACC:   sum_ff <= sum_ff + prod_ff[63:0];
         ST_NRWAIT: if (sq_done) n_ff <= sq_root;
         ST_TACC: begin
            if (idx_ff == 2'd2) begin
               c_ff[idx_ff] <= 34'(UNIT - t_shr);
               sum_ff       <= '0;
            end else begin
               c_ff[idx_ff] <= 34'(-t_shr);
            end
         end
         ST_EMUL2:  p1_ff <= prod_ff[63:0];
         ST_EACC:   e_ff[idx_ff] <= e_clamp;
         default: begin
         end
      endcase
      if (norm_write) begin
         if (pass_ff) begin
            nv_ff[idx_ff] <= norm_word;
         end else begin
            u_ff[idx_ff] <= norm_word;
         end
      end
   end

   ecefenu_divu u_divu (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo)
   );

   ecefenu_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sq_start),
      .radicand (sum_ff),
      .done     (sq_done),
      .root     (sq_root)
   );

   assign ready = ready_ff;
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         basis[i]     = e_ff[i];
         basis[i + 3] = nv_ff[i];
         basis[i + 6] = u_ff[i];
      end
   end

endmodule

// ----- rtl/ecefenu_front.sv -----
`timescale 1ns / 1ps

// Accepts fixes: the first becomes the reference, later ones are
// differenced and queued for the back end.
module ecefenu_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  ecefenu_pkg::pos_type  req_item,
   output logic                  setup_start,
   output ecefenu_pkg::pos_type  setup_ref,
   output logic                  q_valid,
   output ecefenu_pkg::diff_type q_head,
   input  logic                  q_pop
);

   localparam int PTR_W = $clog2(ecefenu_pkg::QUEUE_DEPTH);
   localparam int CNT_W = $clog2(ecefenu_pkg::QUEUE_DEPTH + 1);

   logic                  ref_taken_ff;
   logic                  start_ff;
   ecefenu_pkg::pos_type  ref_ff;
   ecefenu_pkg::diff_type qmem_ff [ecefenu_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]      wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  accept, push_q;
   ecefenu_pkg::diff_type diff;

   assign req_full = (count_ff == CNT_W'(ecefenu_pkg::QUEUE_DEPTH));
   assign accept   = req_push && !req_full;
   assign push_q   = accept && ref_taken_ff;

   assign diff.dx = req_item.pos_x - ref_ff.pos_x;
   assign diff.dy = req_item.pos_y - ref_ff.pos_y;
   assign diff.dz = req_item.pos_z - ref_ff.pos_z;

   always_comb begin
      count_in = count_ff;
      if (push_q && !q_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (!push_q && q_pop) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_taken_ff <= 1'b0;
         start_ff     <= 1'b0;
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         count_ff     <= '0;
      end else begin
         start_ff <= accept && !ref_taken_ff;
         if (accept) begin
            ref_taken_ff <= 1'b1;
         end
         if (push_q) begin
            wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         end
         if (q_pop) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && !ref_taken_ff) begin
         ref_ff <= req_item;
      end
      if (push_q) begin
         qmem_ff[wr_ptr_ff] <= diff;
      end
   end

   assign setup_start = start_ff;
   assign setup_ref   = ref_ff;
   assign q_valid     = (count_ff != '0);
   assign q_head      = qmem_ff[rd_ptr_ff];

endmodule

// ----- rtl/ecefenu_back.sv -----
`timescale 1ns / 1ps

// Projects queued differences onto the basis: products, sums, then
// round and saturate into the result queue.
module ecefenu_back #(
   parameter int BASIS_FRAC_BITS = 30
) (
   input  logic                   clock,
   input  logic                   reset,
   input  ecefenu_pkg::basis_type basis,
   input  logic                   basis_ready,
   input  logic                   q_valid,
   input  ecefenu_pkg::diff_type  q_head,
   output logic                   q_pop,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output ecefenu_pkg::enu_type   rsp_item
);

   localparam int PTR_W = $clog2(ecefenu_pkg::OUT_DEPTH);
   localparam int CNT_W = $clog2(ecefenu_pkg::OUT_DEPTH + 1);
   localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
   localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

   logic                 va_ff, vb_ff;
   logic signed [63:0]   prod_ff [9];
   logic signed [63:0]   acc_ff [3];
   logic signed [31:0]   d [3];
   logic signed [31:0]   res [3];
   logic signed [63:0]   rnd [3];
   ecefenu_pkg::enu_type omem_ff [ecefenu_pkg::OUT_DEPTH];
   ecefenu_pkg::enu_type res_item;
   logic [PTR_W-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [CNT_W:0]       in_use;
   logic                 out_pop;

   assign d[0] = q_head.dx;
   assign d[1] = q_head.dy;
   assign d[2] = q_head.dz;

   // issue only when the result queue has room for everything in flight
   assign in_use = {1'b0, count_ff} + (CNT_W+1)'(va_ff) + (CNT_W+1)'(vb_ff);
   assign q_pop  = q_valid && basis_ready
                && (in_use < (CNT_W+1)'(ecefenu_pkg::OUT_DEPTH));
   assign out_pop = rsp_pop && !rsp_empty;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         rnd[k] = ecefenu_pkg::shr_round(acc_ff[k], BASIS_FRAC_BITS);
         if (rnd[k] > S32_MAX) begin
            res[k] = S32_MAX[31:0];
         end else if (rnd[k] < S32_MIN) begin
            res[k] = S32_MIN[31:0];
         end else begin
            res[k] = rnd[k][31:0];
         end
      end
   end

   assign res_item.east  = res[0];
   assign res_item.north = res[1];
   assign res_item.up    = res[2];

   always_comb begin
      count_in = count_ff;
      if (vb_ff && !out_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (!vb_ff && out_pop) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff     <= 1'b0;
         vb_ff     <= 1'b0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         va_ff <= q_pop;
         vb_ff <= va_ff;
         if (vb_ff) begin
            wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         end
         if (out_pop) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 3; k++) begin
         for (int i = 0; i < 3; i++) begin
            prod_ff[k * 3 + i] <= $signed(basis[k * 3 + i]) * d[i];
         end
         acc_ff[k] <= prod_ff[k * 3] + prod_ff[k * 3 + 1] + prod_ff[k * 3 + 2];
      end
      if (vb_ff) begin
         omem_ff[wr_ptr_ff] <= res_item;
      end
   end

   assign rsp_empty = (count_ff == '0);
   assign rsp_item  = omem_ff[rd_ptr_ff];

endmodule

// ----- rtl/ecef_to_local_enu_core.sv -----
`timescale 1ns / 1ps

// Channel   Ports                          Moves
// -------   -----------------------------  ----------------------------------
// request   req_push, req_full, req_item   one ECEF fix (x, y, z in cm)
// response  rsp_empty, rsp_pop, rsp_item   one east/north/up offset (cm)
//
// The first fix after reset is the reference and yields no transaction;
// basis setup then runs on the serial divider (six divisions) and the serial
// square root (two roots). Later fixes are accepted during setup and wait
// in a 4-entry queue. Once the basis is ready, one fix per cycle enters the
// three-stage dot-product pipe while the result queue has room for every
// fix in flight; products, sums and the rounded result are registered in turn.
// Reset is synchronous and empties both queues; a stalled response side
// fills the 4-entry result queue, then the request queue, then raises req_full.
module ecef_to_local_enu_core #(
   parameter int BASIS_FRAC_BITS = 30
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  ecefenu_pkg::pos_type req_item,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output ecefenu_pkg::enu_type rsp_item
);

   logic                   setup_start;
   ecefenu_pkg::pos_type   setup_ref;
   logic                   q_valid;
   logic                   q_pop;
   ecefenu_pkg::diff_type  q_head;
   logic                   basis_ready;
   ecefenu_pkg::basis_type basis;

   // front: take the reference, difference later fixes, hold them in the queue
   ecefenu_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_item    (req_item),
      .setup_start (setup_start),
      .setup_ref   (setup_ref),
      .q_valid     (q_valid),
      .q_head      (q_head),
      .q_pop       (q_pop)
   );

   // one-time basis construction from the reference
   ecefenu_basis #(
      .BASIS_FRAC_BITS (BASIS_FRAC_BITS)
   ) u_basis (
      .clock   (clock),
      .reset   (reset),
      .start   (setup_start),
      .ref_pos (setup_ref),
      .ready   (basis_ready),
      .basis   (basis)
   );

   // back: advance queued differences through the projection pipe
   ecefenu_back #(
      .BASIS_FRAC_BITS (BASIS_FRAC_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .basis       (basis),
      .basis_ready (basis_ready),
      .q_valid     (q_valid),
      .q_head      (q_head),
      .q_pop       (q_pop),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_item    (rsp_item)
   );

endmodule
